FILE: rtl/core/channel_window_filter_core_macros.svh
// Assertion macros for the channel window filter core.
// Each macro expects clk and rst_n in scope.
`ifndef CHANNEL_WINDOW_FILTER_CORE_MACROS_SVH
`define CHANNEL_WINDOW_FILTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CWF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CWF_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CWF_ASSERT(lbl, prop, msg)
`define CWF_NEVER(lbl, cond, msg)
`endif
`endif

FILE: rtl/core/cwf_pkg.sv
// ----------------------------------------------------------------------------
// cwf_pkg
// Shared constants, widths and types of the channel window filter core.
// ----------------------------------------------------------------------------
`default_nettype none

package cwf_pkg;

    localparam int WINDOW   = 8;
    localparam int CHANNELS = 12;

    localparam int SMP_W   = 16;
    localparam int CH_W    = 4;
    localparam int CHI_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WIN_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int DEPTH   = WINDOW * CHANNELS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int SUM_W   = SMP_W + CNT_W;
    localparam int E_W     = 32;
    localparam int D_W     = 25;
    localparam int NOISE_W = 53;
    localparam int SQ_W    = 56;
    localparam int SQ_IT   = SQ_W / 2;
    localparam int SQI_W   = $clog2(SQ_IT);
    localparam int DV_W    = 36;
    localparam int DEN_W   = 37;
    localparam int NUM_W   = 52;
    localparam int NUMI_W  = $clog2(NUM_W);
    localparam int PW      = E_W + 17;

    localparam logic [15:0] ALPHA   = 16'd19661;
    localparam logic [15:0] ALPHA_C = 16'd45875;
    localparam logic [15:0] W04     = 16'd26214;
    localparam logic [16:0] W06     = 17'd39322;
    localparam logic [16:0] W09     = 17'd58982;
    localparam logic [16:0] ONE     = 17'd65536;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_COUNT = 2'd1;
    localparam logic [1:0] CFG_OE    = 2'd2;

    localparam logic [1:0] MODE_NEWEST = 2'd0;
    localparam logic [1:0] MODE_TRIM   = 2'd1;
    localparam logic [1:0] MODE_MEDIAN = 2'd2;
    localparam logic [1:0] MODE_ADAPT  = 2'd3;

    typedef struct packed {
        logic             tick;
        logic [CH_W-1:0]  channel;
        logic [SMP_W-1:0] sample;
        logic [CH_W-1:0]  count;
    } cwf_item_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } cwf_div_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/cwf_ram.sv
// ----------------------------------------------------------------------------
// cwf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cwf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 96
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/cwf_front.sv
// ----------------------------------------------------------------------------
// cwf_front
// Input side: takes transfers, drops ones with no effect, queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module cwf_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic                     s_axis_tuser,
    input  wire logic [23:0]              s_axis_tdata,
    input  wire logic                     output_enable,
    input  wire logic [cwf_pkg::CH_W-1:0] channel_count,
    output logic                          q_valid,
    output cwf_pkg::cwf_item_t            q_item,
    input  wire logic                     q_pop
);
    import cwf_pkg::*;

    cwf_item_t   slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    cwf_item_t   item;
    logic        keep;
    logic        accept;

    always_comb
    begin
        item.tick    = s_axis_tuser;
        item.channel = s_axis_tdata[3:0];
        item.sample  = s_axis_tdata[19:4];
        item.count   = (channel_count > CH_W'(CHANNELS)) ? CH_W'(CHANNELS) : channel_count;
    end

    assign s_axis_tready = (count_reg != 2'd2);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign keep = accept && (item.tick ? (output_enable && (item.count != '0))
                                       : (item.channel < CH_W'(CHANNELS)));
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (keep)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(keep) - 2'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/cwf_div.sv
// ----------------------------------------------------------------------------
// cwf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cwf_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  cwf_pkg::cwf_div_req_t          req,
    output logic                           done,
    output logic [cwf_pkg::NUM_W-1:0]      quo
);
    import cwf_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [NUMI_W-1:0] cnt_reg;
    logic [NUM_W-1:0]  q_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W:0]    rem_sh;
    logic              fits;

    assign rem_sh = {rem_reg, q_reg[NUM_W-1]};
    assign fits   = (rem_sh >= {1'b0, den_reg});
    assign done   = done_reg;
    assign quo    = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == NUMI_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? DEN_W'(rem_sh - {1'b0, den_reg}) : DEN_W'(rem_sh);
        end
    end

    `include "channel_window_filter_core_macros.svh"
    `CWF_NEVER(a_div_restart, req.start && busy_reg, "divider restarted while busy")
    `CWF_ASSERT(a_div_done, done_reg |-> !busy_reg, "done while busy")
    `CWF_ASSERT(a_div_len, busy_reg && cnt_reg == NUMI_W'(NUM_W - 1) |=> done_reg, "lost done")

endmodule

`default_nettype wire

FILE: rtl/core/cwf_back.sv
// ----------------------------------------------------------------------------
// cwf_back
// Execution side: window update on samples, per-channel filtering on ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module cwf_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [1:0]                filter_mode,
    input  wire logic                      q_valid,
    input  cwf_pkg::cwf_item_t             q_item,
    output logic                           q_pop,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [23:0]                    m_axis_tdata,
    output logic                           m_axis_tlast
);
    import cwf_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_INIT  = 5'd1;
    localparam logic [4:0] S_LOAD  = 5'd2;
    localparam logic [4:0] S_CAP   = 5'd3;
    localparam logic [4:0] S_CALC  = 5'd4;
    localparam logic [4:0] S_SORT  = 5'd5;
    localparam logic [4:0] S_PICK  = 5'd6;
    localparam logic [4:0] S_MED   = 5'd7;
    localparam logic [4:0] S_MUL   = 5'd8;
    localparam logic [4:0] S_EW    = 5'd9;
    localparam logic [4:0] S_SQ    = 5'd10;
    localparam logic [4:0] S_ROOT  = 5'd11;
    localparam logic [4:0] S_WT    = 5'd12;
    localparam logic [4:0] S_WT2   = 5'd13;
    localparam logic [4:0] S_DIV   = 5'd14;
    localparam logic [4:0] S_BLEND = 5'd15;
    localparam logic [4:0] S_FIN   = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;

    logic [4:0]         state_reg;
    logic [CH_W-1:0]    ch_reg;
    logic [CH_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]   fill_reg [CHANNELS];
    logic [WIN_W-1:0]   wp_reg [CHANNELS];
    logic [CNT_W-1:0]   n_reg;
    logic [WIN_W-1:0]   start_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   pass_reg;
    logic [SQI_W-1:0]   sq_cnt_reg;

    logic [SMP_W-1:0]   x_reg [WINDOW];
    logic [SUM_W-1:0]   sum_reg;
    logic [SMP_W-1:0]   mx_reg;
    logic [SMP_W-1:0]   mn_reg;
    logic [SMP_W-1:0]   m_reg;
    logic [30:0]        p1_reg;
    logic [47:0]        p2_reg;
    logic [E_W-1:0]     e1_reg;
    logic [E_W-1:0]     e2_reg;
    logic [D_W-1:0]     d_reg;
    logic [NOISE_W-1:0] noise_reg;
    logic [SQ_W-1:0]    sq_v_reg;
    logic [SQ_W-1:0]    sq_r_reg;
    logic [SQ_W-1:0]    sq_bit_reg;
    logic [NUM_W-1:0]   prod_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [PW-1:0]      pa_reg;
    logic [PW-1:0]      pb_reg;
    logic [SMP_W-1:0]   res_reg;
    logic               out_valid_reg;
    logic [CH_W-1:0]    out_ch_reg;
    logic [SMP_W-1:0]   out_val_reg;
    logic               out_last_reg;

    logic [CHI_W-1:0]   fidx;
    logic [CNT_W-1:0]   fcur;
    logic [WIN_W-1:0]   wcur;
    logic               ram_we;
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W-1:0]  raddr;
    logic [SMP_W-1:0]   rdata;
    logic [CNT_W:0]     pos;
    logic [WIN_W-1:0]   rpos;
    logic [CNT_W:0]     st_sum;
    logic [WIN_W-1:0]   st_val;
    logic [SMP_W-1:0]   sorted [WINDOW];
    logic [WIN_W-1:0]   i0;
    logic [WIN_W-1:0]   im;
    logic [WIN_W-1:0]   ip;
    logic [WIN_W-1:0]   nl;
    logic [SMP_W-1:0]   lo_ab;
    logic [SMP_W-1:0]   hi_ab;
    logic [SMP_W-1:0]   med3;
    logic [SMP_W-1:0]   hi_c;
    logic [48:0]        ew_sum;
    logic [E_W-1:0]     e_new;
    logic [E_W-1:0]     e_diff;
    logic [E_W:0]       d_rnd;
    logic [NOISE_W-1:0] noise_sum;
    logic [SQ_W-1:0]    sq_trial;
    logic [DV_W-1:0]    dv;
    logic [NUM_W-1:0]   quo;
    logic               div_done;
    logic [16:0]        a_raw;
    logic [16:0]        a_cl;
    logic [PW:0]        y_sum;
    logic [17:0]        y_val;
    logic [SMP_W:0]     pick_sum;
    logic [WIN_W-1:0]   mid_hi;
    logic [WIN_W-1:0]   mid_lo;
    logic               out_free;
    logic               last_ch;
    cwf_div_req_t       div_req;

    assign fidx = (state_reg == S_IDLE) ? CHI_W'(q_item.channel) : CHI_W'(ch_reg);
    assign fcur = fill_reg[fidx];
    assign wcur = wp_reg[fidx];

    assign q_pop  = (state_reg == S_IDLE) && q_valid;
    assign ram_we = q_pop && !q_item.tick;
    assign waddr  = ADDR_W'(fidx * WINDOW) + ADDR_W'(wcur);

    assign pos   = (CNT_W + 1)'(start_reg) + (CNT_W + 1)'(idx_reg);
    assign rpos  = (pos >= (CNT_W + 1)'(WINDOW)) ? WIN_W'(pos - (CNT_W + 1)'(WINDOW))
                                                 : WIN_W'(pos);
    assign raddr = ADDR_W'(ch_reg * WINDOW) + ADDR_W'(rpos);

    assign st_sum = (CNT_W + 1)'(wcur) + (CNT_W + 1)'(WINDOW) - (CNT_W + 1)'(fcur);
    assign st_val = (st_sum >= (CNT_W + 1)'(WINDOW)) ? WIN_W'(st_sum - (CNT_W + 1)'(WINDOW))
                                                     : WIN_W'(st_sum);

    cwf_ram #(
        .WIDTH (SMP_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (q_item.sample),
        .raddr (raddr),
        .rdata (rdata)
    );

    // odd-even transposition pass
    always_comb
    begin
        for (int k = 0; k < WINDOW; k++)
        begin
            sorted[k] = x_reg[k];
        end
        for (int k = 0; k < WINDOW - 1; k++)
        begin
            if (((k % 2) == int'(pass_reg[0])) && (x_reg[k] > x_reg[k + 1]))
            begin
                sorted[k]     = x_reg[k + 1];
                sorted[k + 1] = x_reg[k];
            end
        end
    end

    // three-point median at idx, max of two points at either end
    assign i0    = WIN_W'(idx_reg);
    assign im    = i0 - 1'b1;
    assign ip    = i0 + 1'b1;
    assign nl    = WIN_W'(n_reg - 1'b1);
    assign lo_ab = (x_reg[im] < x_reg[i0]) ? x_reg[im] : x_reg[i0];
    assign hi_ab = (x_reg[im] > x_reg[i0]) ? x_reg[im] : x_reg[i0];
    assign hi_c  = (hi_ab < x_reg[ip]) ? hi_ab : x_reg[ip];

    always_comb
    begin
        if (idx_reg == '0)
        begin
            med3 = (x_reg[0] > x_reg[1]) ? x_reg[0] : x_reg[1];
        end
        else if (i0 == nl)
        begin
            med3 = hi_ab;
        end
        else
        begin
            med3 = (lo_ab > hi_c) ? lo_ab : hi_c;
        end
    end

    assign ew_sum    = {p1_reg, 16'd0} + 49'(p2_reg) + 49'd32768;
    assign e_new     = (idx_reg == '0) ? {m_reg, 16'd0} : ew_sum[E_W+15:16];
    assign e_diff    = (e_new >= e1_reg) ? (e_new - e1_reg) : (e1_reg - e_new);
    assign d_rnd     = (E_W + 1)'(e_diff) + (E_W + 1)'(128);
    assign noise_sum = noise_reg + NOISE_W'(d_reg * d_reg);
    assign sq_trial  = sq_r_reg + sq_bit_reg;
    assign dv        = DV_W'({sq_r_reg, 8'd0}) + DV_W'(1);

    assign a_raw = (quo >= NUM_W'(ONE)) ? 17'd0 : (ONE - 17'(quo));
    assign a_cl  = (a_raw < W06) ? W06 : ((a_raw > W09) ? W09 : a_raw);
    assign y_sum = (PW + 1)'(pa_reg) + (PW + 1)'(pb_reg) + ((PW + 1)'(1) << 31);
    assign y_val = y_sum[PW:32];

    assign mid_hi   = WIN_W'(n_reg >> 1);
    assign mid_lo   = mid_hi - 1'b1;
    assign pick_sum = (SMP_W + 1)'(x_reg[mid_lo]) + (SMP_W + 1)'(x_reg[mid_hi]);

    assign out_free = !out_valid_reg || m_axis_tready;
    assign last_ch  = (ch_reg == cnt_reg - 1'b1);

    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = prod_reg + NUM_W'(den_reg >> 1);
        div_req.den   = den_reg;
        if (state_reg == S_CALC)
        begin
            div_req.start = (filter_mode == MODE_TRIM);
            if (n_reg <= CNT_W'(2))
            begin
                div_req.num = NUM_W'(sum_reg);
                div_req.den = DEN_W'(n_reg);
            end
            else
            begin
                div_req.num = NUM_W'(sum_reg - SUM_W'(mx_reg) - SUM_W'(mn_reg));
                div_req.den = DEN_W'(n_reg - CNT_W'(2));
            end
        end
        else if (state_reg == S_WT2)
        begin
            div_req.start = 1'b1;
        end
    end

    cwf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo   (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= '0;
            cnt_reg       <= '0;
            n_reg         <= '0;
            idx_reg       <= '0;
            pass_reg      <= '0;
            sq_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                fill_reg[c] <= '0;
                wp_reg[c]   <= '0;
            end
        end
        else
        begin
            if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_item.tick)
                        begin
                            ch_reg    <= '0;
                            cnt_reg   <= q_item.count;
                            state_reg <= S_INIT;
                        end
                        else
                        begin
                            wp_reg[fidx] <= (wcur == WIN_W'(WINDOW - 1)) ? '0 : wcur + 1'b1;
                            if (fcur < CNT_W'(WINDOW))
                            begin
                                fill_reg[fidx] <= fcur + 1'b1;
                            end
                        end
                    end
                end
                S_INIT:
                begin
                    n_reg     <= fcur;
                    idx_reg   <= '0;
                    state_reg <= (fcur == '0) ? S_OUT : S_LOAD;
                end
                S_LOAD:
                begin
                    state_reg <= S_CAP;
                end
                S_CAP:
                begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= (idx_reg + 1'b1 == n_reg) ? S_CALC : S_LOAD;
                end
                S_CALC:
                begin
                    pass_reg <= '0;
                    idx_reg  <= '0;
                    case (filter_mode)
                        MODE_NEWEST: state_reg <= S_OUT;
                        MODE_TRIM:   state_reg <= S_DIV;
                        MODE_MEDIAN: state_reg <= S_SORT;
                        default:     state_reg <= (n_reg == CNT_W'(1)) ? S_OUT : S_MED;
                    endcase
                end
                S_SORT:
                begin
                    pass_reg <= pass_reg + 1'b1;
                    if (pass_reg == CNT_W'(WINDOW - 1))
                    begin
                        state_reg <= S_PICK;
                    end
                end
                S_PICK:
                begin
                    state_reg <= S_OUT;
                end
                S_MED:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_EW;
                end
                S_EW:
                begin
                    if (idx_reg == '0)
                    begin
                        idx_reg   <= CNT_W'(1);
                        state_reg <= S_MED;
                    end
                    else
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    idx_reg    <= idx_reg + 1'b1;
                    sq_cnt_reg <= '0;
                    state_reg  <= (idx_reg + 1'b1 == n_reg) ? S_ROOT : S_MED;
                end
                S_ROOT:
                begin
                    sq_cnt_reg <= sq_cnt_reg + 1'b1;
                    if (sq_cnt_reg == SQI_W'(SQ_IT - 1))
                    begin
                        state_reg <= S_WT;
                    end
                end
                S_WT:
                begin
                    state_reg <= S_WT2;
                end
                S_WT2:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= (filter_mode == MODE_TRIM) ? S_OUT : S_BLEND;
                    end
                end
                S_BLEND:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        ch_reg        <= ch_reg + 1'b1;
                        state_reg     <= last_ch ? S_IDLE : S_INIT;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_INIT:
            begin
                start_reg <= st_val;
                sum_reg   <= '0;
                mx_reg    <= '0;
                mn_reg    <= '1;
                res_reg   <= '0;
                for (int k = 0; k < WINDOW; k++)
                begin
                    x_reg[k] <= '1;
                end
            end
            S_CAP:
            begin
                x_reg[WIN_W'(idx_reg)] <= rdata;
                sum_reg <= sum_reg + SUM_W'(rdata);
                mx_reg  <= (rdata > mx_reg) ? rdata : mx_reg;
                mn_reg  <= (rdata < mn_reg) ? rdata : mn_reg;
            end
            S_CALC:
            begin
                noise_reg <= '0;
                res_reg   <= (filter_mode == MODE_NEWEST) ? x_reg[nl] : x_reg[0];
            end
            S_SORT:
            begin
                for (int k = 0; k < WINDOW; k++)
                begin
                    x_reg[k] <= sorted[k];
                end
            end
            S_PICK:
            begin
                res_reg <= n_reg[0] ? x_reg[mid_hi] : pick_sum[SMP_W:1];
            end
            S_MED:
            begin
                m_reg <= med3;
            end
            S_MUL:
            begin
                p1_reg <= 31'(ALPHA[14:0] * m_reg);
                p2_reg <= 48'(ALPHA_C * e1_reg);
            end
            S_EW:
            begin
                e1_reg <= e_new;
                e2_reg <= e1_reg;
                d_reg  <= d_rnd[E_W:8];
            end
            S_SQ:
            begin
                noise_reg  <= noise_sum;
                sq_v_reg   <= SQ_W'(noise_sum);
                sq_r_reg   <= '0;
                sq_bit_reg <= SQ_W'(1) << (SQ_W - 2);
            end
            S_ROOT:
            begin
                if (sq_v_reg >= sq_trial)
                begin
                    sq_v_reg <= sq_v_reg - sq_trial;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            S_WT:
            begin
                prod_reg <= NUM_W'(W04[14:0] * dv);
                den_reg  <= DEN_W'(dv) + DEN_W'(e1_reg);
            end
            S_DIV:
            begin
                res_reg <= quo[SMP_W-1:0];
            end
            S_BLEND:
            begin
                pa_reg <= PW'(a_cl * e1_reg);
                pb_reg <= PW'((ONE - a_cl) * e2_reg);
            end
            S_FIN:
            begin
                res_reg <= (y_val > 18'd65535) ? '1 : y_val[SMP_W-1:0];
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_ch_reg   <= ch_reg;
                    out_val_reg  <= res_reg;
                    out_last_reg <= last_ch;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_val_reg, out_ch_reg};
    assign m_axis_tlast  = out_last_reg;

    `include "channel_window_filter_core_macros.svh"
    `CWF_ASSERT(a_pop_idle, q_pop |-> state_reg == S_IDLE, "queue popped while busy")
    `CWF_ASSERT(a_ch_range, state_reg != S_IDLE |-> ch_reg < CH_W'(CHANNELS),
                "channel counter out of range")
    `CWF_ASSERT(a_last_idle, state_reg == S_OUT && out_free && last_ch |=> state_reg == S_IDLE,
                "tick did not end after last channel")
    `CWF_ASSERT(a_fill_max, state_reg == S_INIT |-> fcur <= CNT_W'(WINDOW),
                "fill count above window")

endmodule

`default_nettype wire

FILE: rtl/core/channel_window_filter_core.sv
// Sample transfer: accepted, queued, then applied by the back end once it is idle and pops it.
// Tick: per reported channel, time set by window reads and, by mode, the serial divider
// (trimmed mean, adaptive) and the serial square root (adaptive).
// Next item accepted while the two-entry queue has room.
// Reset (rst_n low, async): windows empty, mode 0, 12 channels, output enabled.
// ----------------------------------------------------------------------------
// channel_window_filter_core
// Per-channel sliding-window filter with newest, trimmed mean, median, adaptive modes.
// ----------------------------------------------------------------------------
`default_nettype none

module channel_window_filter_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // channel[3:0], sample[19:4]
    input  wire logic        s_axis_tuser,   // cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // out_channel[3:0], filtered[19:4]
    output logic             m_axis_tlast,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [3:0]  cfg_wdata
);
    import cwf_pkg::*;

    logic [1:0]      mode_reg;
    logic [CH_W-1:0] count_reg;
    logic            oe_reg;
    logic            q_valid;
    logic            q_pop;
    cwf_item_t       q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NEWEST;
            count_reg <= CH_W'(CHANNELS);
            oe_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_wdata[1:0];
                CFG_COUNT: count_reg <= cfg_wdata;
                CFG_OE:    oe_reg    <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    cwf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .output_enable (oe_reg),
        .channel_count (count_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    cwf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .filter_mode   (mode_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: dv/channel_window_filter_core_tb.sv
// ----------------------------------------------------------------------------
// channel_window_filter_core_tb
// Drives sample and tick transfers into the window filter core under several
// register settings and idling phases; an in-bench predictor of the windows and
// all four filter modes supplies the expected filtered values for each tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module channel_window_filter_core_tb;
    import cwf_pkg::*;

    localparam int WDOG_LIMIT = 20000;
    localparam int IDLE_WAIT  = 3000;

    typedef struct packed {
        logic [3:0]  chan;
        logic [15:0] value;
        logic        last;
    } filt_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [3:0]  cfg_wdata;

    logic [15:0] win_mem [CHANNELS][WINDOW];
    int unsigned win_fill [CHANNELS];
    int unsigned win_wptr [CHANNELS];
    logic [1:0]  mode_q;
    logic [3:0]  count_q;
    logic        oe_q;

    filt_res_t   expected_q[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          wdog;

    channel_window_filter_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic int unsigned umax(int unsigned a, int unsigned b);
        return (a > b) ? a : b;
    endfunction

    function automatic int unsigned umin(int unsigned a, int unsigned b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [15:0] adaptive_value(int unsigned x[WINDOW], int unsigned n);
        int unsigned     m [WINDOW];
        longint unsigned e [WINDOW];
        longint unsigned noise, r, d, l, den, t, a, y;
        noise = 0;
        if (n == 1)
            return x[0][15:0];
        for (int i = 0; i < n; i++)
        begin
            if (i == 0)
                m[i] = umax(x[0], x[1]);
            else if (i == n - 1)
                m[i] = umax(x[n-2], x[n-1]);
            else
                m[i] = umax(umin(x[i-1], x[i]), umin(umax(x[i-1], x[i]), x[i+1]));
        end
        e[0] = longint'(m[0]) << 16;
        for (int i = 1; i < n; i++)
            e[i] = (64'(ALPHA) * (longint'(m[i]) << 16) + 64'(ALPHA_C) * e[i-1]
                    + 32768) >> 16;
        for (int i = 1; i < n; i++)
        begin
            d = (e[i] >= e[i-1]) ? e[i] - e[i-1] : e[i-1] - e[i];
            d = (d + 128) >> 8;
            noise += d * d;
        end
        r   = isqrt(noise);
        den = (r << 8) + 1;
        l   = e[n-1];
        t   = (64'(W04) * den + (den + l) / 2) / (den + l);
        a   = (t >= 65536) ? 0 : 65536 - t;
        if (a < 64'(W06))
            a = 64'(W06);
        if (a > 64'(W09))
            a = 64'(W09);
        y = (a * e[n-1] + (65536 - a) * e[n-2] + (64'd1 << 31)) >> 32;
        return (y > 65535) ? 16'hFFFF : y[15:0];
    endfunction

    function automatic logic [15:0] channel_value(int ch);
        int unsigned     x [WINDOW];
        int unsigned     s [WINDOW];
        int unsigned     n, st, mx, mn, v;
        int              j;
        longint unsigned sum;
        n = win_fill[ch];
        sum = 0;
        if (n == 0)
            return 16'd0;
        st = (win_wptr[ch] + WINDOW - n) % WINDOW;
        for (int i = 0; i < n; i++)
            x[i] = win_mem[ch][(st + i) % WINDOW];
        case (mode_q)
            MODE_NEWEST: return x[n-1][15:0];
            MODE_TRIM:
            begin
                mx = x[0];
                mn = x[0];
                for (int i = 0; i < n; i++)
                begin
                    sum += x[i];
                    mx = umax(mx, x[i]);
                    mn = umin(mn, x[i]);
                end
                if (n <= 2)
                    return 16'(sum / n);
                return 16'((sum - mx - mn) / (n - 2));
            end
            MODE_MEDIAN:
            begin
                for (int i = 0; i < n; i++)
                begin
                    v = x[i];
                    j = i;
                    while (j > 0 && s[j-1] > v)
                    begin
                        s[j] = s[j-1];
                        j--;
                    end
                    s[j] = v;
                end
                if (n % 2)
                    return s[n/2][15:0];
                return 16'((s[n/2-1] + s[n/2]) / 2);
            end
            default: return adaptive_value(x, n);
        endcase
    endfunction

    function automatic void predict_item(bit tick, int ch, logic [15:0] smp);
        filt_res_t r;
        int        cnt;
        if (!tick)
        begin
            if (ch >= CHANNELS)
                return;
            win_mem[ch][win_wptr[ch]] = smp;
            win_wptr[ch] = (win_wptr[ch] + 1) % WINDOW;
            if (win_fill[ch] < WINDOW)
                win_fill[ch]++;
            return;
        end
        if (!oe_q)
            return;
        cnt = (count_q > CHANNELS) ? CHANNELS : count_q;
        for (int i = 0; i < cnt; i++)
        begin
            r.chan  = 4'(i);
            r.value = channel_value(i);
            r.last  = (i == cnt - 1);
            expected_q.push_back(r);
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        filt_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected result, channel", m_axis_tdata[3:0], -1);
            else
            begin
                want = expected_q.pop_front();
                if (m_axis_tdata[3:0] != want.chan)
                    report_mismatch("out_channel", m_axis_tdata[3:0], want.chan);
                if (m_axis_tdata[19:4] != want.value)
                    report_mismatch("filtered", m_axis_tdata[19:4], want.value);
                if (m_axis_tdata[23:20] != 4'd0)
                    report_mismatch("tdata pad", m_axis_tdata[23:20], 0);
                if (m_axis_tlast != want.last)
                    report_mismatch("tlast", m_axis_tlast, want.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_item(bit tick, logic [3:0] ch, logic [15:0] smp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= tick;
        s_axis_tdata  <= {4'd0, smp, ch};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_item(tick, ch, smp);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_MODE:  mode_q  = val[1:0];
            CFG_COUNT: count_q = val;
            CFG_OE:    oe_q    = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_idling(int snd, int rcv);
        send_idle_pct  = snd;
        recv_stall_pct = rcv;
    endtask

    task automatic test_directed();
        write_reg(CFG_MODE, MODE_NEWEST);
        send_item(1'b1, 4'd0, 16'd0);
        send_item(1'b0, 4'd0, 16'hFFFF);
        send_item(1'b0, 4'd1, 16'd0);
        send_item(1'b0, 4'd11, 16'h8001);
        send_item(1'b0, 4'd15, 16'h1234);
        send_item(1'b0, 4'd12, 16'h7FFE);
        for (int i = 0; i < 10; i++)
            send_item(1'b0, 4'd2, 16'(i * 7000 + 1));
        send_item(1'b0, 4'd3, 16'hFFFF);
        send_item(1'b0, 4'd3, 16'hFFFF);
        for (int md = 0; md < 4; md++)
        begin
            drain();
            write_reg(CFG_MODE, 2'(md));
            send_item(1'b1, 4'hF, 16'hFFFF);
        end
        drain();
        write_reg(CFG_OE, 1'b0);
        send_item(1'b1, 4'd0, 16'd0);
        send_item(1'b0, 4'd4, 16'd500);
        drain();
        write_reg(CFG_OE, 1'b1);
        write_reg(CFG_COUNT, 4'd0);
        send_item(1'b1, 4'd0, 16'd0);
        drain();
        write_reg(CFG_COUNT, 4'd15);
        send_item(1'b1, 4'd0, 16'd0);
        drain();
        write_reg(CFG_COUNT, 4'd1);
        write_reg(2'd3, 4'd5);
        send_item(1'b1, 4'd0, 16'd0);
        drain();
    endtask

    task automatic test_random(int items, int mode, int cnt, int snd, int rcv);
        logic [15:0] base;
        write_reg(CFG_MODE, 2'(mode));
        write_reg(CFG_COUNT, 4'(cnt));
        write_reg(CFG_OE, 1'b1);
        set_idling(snd, rcv);
        base = 16'($urandom);
        for (int i = 0; i < items; i++)
        begin
            if ($urandom_range(9) == 0)
                send_item(1'b1, 4'($urandom), 16'($urandom));
            else if ($urandom_range(19) == 0)
                send_item(1'b0, 4'($urandom_range(15, 12)), 16'($urandom));
            else if ($urandom_range(3) == 0)
                send_item(1'b0, 4'($urandom_range(11)), 16'($urandom));
            else
                send_item(1'b0, 4'($urandom_range(11)), base + 16'($urandom_range(2000)));
        end
        send_item(1'b1, 4'd0, 16'd0);
        drain();
    endtask

    task automatic test_pause_for_results();
        set_idling(0, 0);
        send_item(1'b1, 4'd0, 16'd0);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        send_item(1'b1, 4'd0, 16'd0);
        drain();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        m_axis_tready  = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mode_q         = MODE_NEWEST;
        count_q        = 4'd12;
        oe_q           = 1'b1;
        for (int c = 0; c < CHANNELS; c++)
        begin
            win_fill[c] = 0;
            win_wptr[c] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(60, MODE_ADAPT, 12, 0, 0);
        test_random(50, MODE_TRIM, 5, 79, 0);
        test_random(50, MODE_MEDIAN, 12, 0, 79);
        test_random(50, MODE_ADAPT, 1, 7, 7);
        test_random(40, MODE_NEWEST, 9, 0, 0);
        test_pause_for_results();

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/cwf_pkg.sv
rtl/core/cwf_ram.sv
rtl/core/cwf_front.sv
rtl/core/cwf_div.sv
rtl/core/cwf_back.sv
rtl/core/channel_window_filter_core.sv
dv/channel_window_filter_core_tb.sv
